@@ src/wth_pkg.sv @@
// package: shared types, constants and hash helpers for the whitespace token hasher
package wth_pkg;

  localparam logic [31:0] HashBasis = 32'd2166136261;
  localparam logic [30:0] IdMask = 31'h7FFF_FFFF;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
  localparam logic [31:0] CapacityReset = 32'd65535;
  localparam int unsigned QueueDepthDefault = 4;
  localparam int unsigned CfgIndexWidth = 8;
  localparam logic [CfgIndexWidth-1:0] RegCapacity = CfgIndexWidth'(0);
  localparam logic [CfgIndexWidth-1:0] RegSizeQuery = CfgIndexWidth'(1);

  typedef struct packed {
    logic       has_byte;
    logic [7:0] text_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic        is_report;
    logic [30:0] token_id;
    logic [31:0] token_count;
    logic        status;
    logic        last_of_run;
  } token_item_t;

  typedef struct packed {
    logic       add_byte;
    logic       close_token;
    logic       end_of_text;
    logic [7:0] text_byte;
  } cmd_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  // fnv-1a step, prime 0x01000193 as shift-add
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == CountMax) ? v : v + 32'd1;
  endfunction

endpackage

@@ src/wth_front.sv @@
// front end: accepts text items, classifies bytes and drops empty items
module wth_front
  import wth_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_ready,
  input  text_item_t text,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_cmd
);

  logic ws;

  always_comb begin
    ws = text.has_byte & is_ws(text.text_byte);
    text_ready = push_ready;
    push_valid = text_valid & (text.has_byte | text.end_of_text);
    push_cmd.add_byte = text.has_byte & ~ws;
    push_cmd.close_token = ws;
    push_cmd.end_of_text = text.end_of_text;
    push_cmd.text_byte = text.text_byte;
  end

`ifndef SYNTHESIS
  a_no_empty_push: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_cmd.add_byte | push_cmd.close_token | push_cmd.end_of_text))
    else $error("empty item pushed");
  a_class_exclusive: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> !(push_cmd.add_byte && push_cmd.close_token))
    else $error("byte both hashed and closing");
  a_ready_from_queue: assert property (@(posedge clk) disable iff (rst)
    (text_valid && text_ready) |-> (push_ready || !push_valid))
    else $error("item accepted while queue full");
`endif

endmodule

@@ src/wth_fifo.sv @@
// short command queue between front and back
module wth_fifo
  import wth_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntWidth = $clog2(Depth + 1);
  localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
  localparam logic [CntWidth-1:0] Full = CntWidth'(Depth);

  cmd_t                mem [Depth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic                do_push;
  logic                do_pop;

  always_comb begin
    push_ready = (count != Full);
    head_valid = (count != '0);
    head_cmd = mem[rd_ptr];
    do_push = push_valid & push_ready;
    do_pop = pop & head_valid;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrWidth'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + CntWidth'(1);
        2'b01:   count <= count - CntWidth'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/wth_back.sv @@
// back end: token state, fnv-1a hashing, counting and result register
module wth_back
  import wth_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] capacity,
  input  logic        size_query,
  input  logic        head_valid,
  input  cmd_t        head_cmd,
  output logic        pop,
  output logic        token_valid,
  input  logic        token_ready,
  output token_item_t token
);

  logic        in_token;
  logic [31:0] hash;
  logic [31:0] seen;
  logic [31:0] written;
  logic        pend;

  logic [31:0] hash_in;
  logic [31:0] hash_upd;
  logic        in_token_upd;
  logic        do_close;
  logic        emit_id;
  logic [31:0] seen_upd;
  logic [31:0] written_upd;
  logic [30:0] id_raw;
  logic        adv;
  logic        fire;
  logic        split;
  logic        has_result;
  token_item_t result;

  always_comb begin
    hash_in = in_token ? hash : HashBasis;
    hash_upd = head_cmd.add_byte ? fnv_step(hash_in, head_cmd.text_byte) : hash;
    in_token_upd = in_token | head_cmd.add_byte;
    do_close = (head_cmd.close_token | head_cmd.end_of_text) & in_token_upd & ~pend;
    emit_id = do_close & ~size_query & (written < capacity);
    seen_upd = do_close ? sat_inc(seen) : seen;
    written_upd = emit_id ? sat_inc(written) : written;
    id_raw = hash_upd[30:0] & IdMask;
    adv = ~token_valid | token_ready;
    fire = head_valid & adv;
    split = emit_id & head_cmd.end_of_text;
    pop = fire & ~split;
    has_result = emit_id | head_cmd.end_of_text;
    if (emit_id) begin
      result.is_report = 1'b0;
      result.token_id = (id_raw == '0) ? 31'd1 : id_raw;
      result.token_count = '0;
      result.status = 1'b0;
      result.last_of_run = ~head_cmd.end_of_text;
    end else begin
      result.is_report = 1'b1;
      result.token_id = '0;
      result.token_count = size_query ? seen_upd : written_upd;
      result.status = ~size_query & (written_upd != seen_upd);
      result.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token <= 1'b0;
      hash <= HashBasis;
      seen <= '0;
      written <= '0;
      pend <= 1'b0;
      token_valid <= 1'b0;
    end else if (fire) begin
      token_valid <= has_result;
      token <= result;
      if (head_cmd.end_of_text && !split) begin
        in_token <= 1'b0;
        hash <= HashBasis;
        seen <= '0;
        written <= '0;
        pend <= 1'b0;
      end else begin
        in_token <= do_close ? 1'b0 : in_token_upd;
        hash <= do_close ? HashBasis : hash_upd;
        seen <= seen_upd;
        written <= written_upd;
        pend <= split;
      end
    end else if (adv) begin
      token_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_pend_after_id: assert property (@(posedge clk) disable iff (rst)
    pend |-> (token_valid && !token.is_report && !token.last_of_run))
    else $error("pending report without open token id");
  a_written_le_seen: assert property (@(posedge clk) disable iff (rst)
    written <= seen)
    else $error("written count exceeds seen count");
  a_report_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && head_cmd.end_of_text && !split) |=>
      (!pend && !in_token && seen == '0 && written == '0))
    else $error("state not cleared after report");
`endif

endmodule

@@ src/whitespace_token_hasher_top.sv @@
// top level: configuration registers, front end, command queue and back end
// path: a text item is queued, then its result is registered in the output register
// throughput: one item per cycle unless the output stalls; an end item closing an emitted token
// yields the token id and then the report through the single result register
// reset: synchronous active high rst clears the queue, token state and counts; capacity
// returns to 65535 and size_query to 0
module whitespace_token_hasher_top
  import wth_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     text_valid,
  output logic                     text_ready,
  input  text_item_t               text,
  output logic                     token_valid,
  input  logic                     token_ready,
  output token_item_t              token,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [31:0]              cfg_data
);

  logic [31:0] capacity;
  logic        size_query;
  logic        push_valid;
  logic        push_ready;
  cmd_t        push_cmd;
  logic        head_valid;
  cmd_t        head_cmd;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CapacityReset;
      size_query <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == RegCapacity) begin
        capacity <= cfg_data;
      end else if (cfg_index == RegSizeQuery) begin
        size_query <= cfg_data[0];
      end
    end
  end

  wth_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text       (text),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  wth_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  wth_back u_back (
    .clk         (clk),
    .rst         (rst),
    .capacity    (capacity),
    .size_query  (size_query),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .token       (token)
  );

endmodule

@@ tb/tb_whitespace_token_hasher_top.sv @@
// testbench: random and directed text streams into the token hasher, token items checked by a scoreboard
module tb_whitespace_token_hasher_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wth_pkg::*;

  localparam logic [31:0] FnvPrime = 32'd16777619;
  localparam int SettleCycles = 10;
  localparam int LongHold = 300;
  localparam int CycleLimit = 300000;
  localparam int PhaseItems = 110;

  class token_scoreboard;
    logic [31:0] capacity;
    logic        size_query;
    logic        in_token;
    logic [31:0] hash;
    logic [31:0] seen;
    logic [31:0] written;
    token_item_t pending_tokens[$];
    token_item_t run[$];
    int          errors;

    function new();
      capacity = CapacityReset;
      size_query = 1'b0;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      in_token = 1'b0;
      hash = HashBasis;
      seen = '0;
      written = '0;
    endfunction

    function logic [31:0] count_up(logic [31:0] v);
      return (v == CountMax) ? v : v + 32'd1;
    endfunction

    function bit is_space(logic [7:0] b);
      return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function void add_result(logic rep, logic [30:0] id, logic [31:0] cnt, logic st);
      token_item_t r;
      r.is_report = rep;
      r.token_id = id;
      r.token_count = cnt;
      r.status = st;
      r.last_of_run = 1'b0;
      run.push_back(r);
    endfunction

    function void close_open();
      logic [30:0] id;
      if (in_token) begin
        if (!size_query && written < capacity) begin
          id = hash[30:0] & IdMask;
          if (id == '0) id = 31'd1;
          add_result(1'b0, id, '0, 1'b0);
          written = count_up(written);
        end
        seen = count_up(seen);
        in_token = 1'b0;
        hash = HashBasis;
      end
    endfunction

    function void write_reg(logic [CfgIndexWidth-1:0] idx, logic [31:0] val);
      if (idx == RegCapacity) capacity = val;
      else if (idx == RegSizeQuery) size_query = val[0];
    endfunction

    function void note_text(text_item_t it);
      token_item_t r;
      run.delete();
      if (it.has_byte) begin
        if (is_space(it.text_byte)) begin
          close_open();
        end else begin
          if (!in_token) begin
            in_token = 1'b1;
            hash = HashBasis;
          end
          hash = (hash ^ {24'd0, it.text_byte}) * FnvPrime;
        end
      end
      if (it.end_of_text) begin
        close_open();
        if (size_query) add_result(1'b1, '0, seen, 1'b0);
        else add_result(1'b1, '0, written, written != seen);
        clear_text();
      end
      if (run.size() != 0) begin
        r = run.pop_back();
        r.last_of_run = 1'b1;
        run.push_back(r);
      end
      foreach (run[i]) pending_tokens.push_back(run[i]);
    endfunction

    function void check_token(token_item_t got);
      token_item_t want;
      if (pending_tokens.size() == 0) begin
        if (errors < 10)
          $display("unexpected token item: rep=%0d id=%h cnt=%0d st=%0d last=%0d",
                   got.is_report, got.token_id, got.token_count, got.status, got.last_of_run);
        errors++;
        return;
      end
      want = pending_tokens.pop_front();
      if (got.is_report !== want.is_report || got.token_id !== want.token_id ||
          got.token_count !== want.token_count || got.status !== want.status ||
          got.last_of_run !== want.last_of_run) begin
        if (errors < 10) begin
          $display("mismatch exp: rep=%0d id=%h cnt=%0d st=%0d last=%0d",
                   want.is_report, want.token_id, want.token_count, want.status,
                   want.last_of_run);
          $display("         got: rep=%0d id=%h cnt=%0d st=%0d last=%0d",
                   got.is_report, got.token_id, got.token_count, got.status, got.last_of_run);
        end
        errors++;
      end
    endfunction

    function int pending();
      return pending_tokens.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     text_valid = 1'b0;
  logic                     text_ready;
  text_item_t               text = '0;
  logic                     token_valid;
  logic                     token_ready = 1'b0;
  token_item_t              token;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [31:0]              cfg_data = '0;

  token_scoreboard sb;
  text_item_t      text_buf[$];
  int              items_sent = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              hold_requests = 0;
  int              hold_served = 0;
  int              hold_left = 0;
  int              cycles = 0;

  whitespace_token_hasher_top dut (
    .clk(clk),
    .rst(rst),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text(text),
    .token_valid(token_valid),
    .token_ready(token_ready),
    .token(token),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && token_valid && token_ready) sb.check_token(token);
  end

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LongHold;
      token_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      token_ready <= 1'b0;
    end else begin
      token_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [7:0] token_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] space_byte();
    int k;
    k = $urandom_range(5);
    return (k == 5) ? 8'h20 : 8'(8'h09 + k);
  endfunction

  task automatic add_item(logic has, logic [7:0] b, logic eot);
    text_item_t it;
    it.has_byte = has;
    it.text_byte = b;
    it.end_of_text = eot;
    text_buf.push_back(it);
  endtask

  task automatic send_text(text_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      @(negedge clk);
    end
    text_valid <= 1'b1;
    text <= it;
    @(posedge clk);
    while (!text_ready) @(posedge clk);
    sb.note_text(it);
    if (it.has_byte || it.end_of_text) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_buf();
    foreach (text_buf[i]) send_text(text_buf[i]);
    text_buf.delete();
  endtask

  task automatic drain();
    text_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic configure(logic [31:0] cap, logic sq);
    logic [CfgIndexWidth-1:0] idx[3];
    logic [31:0]              val[3];
    drain();
    idx[0] = CfgIndexWidth'($urandom_range(2, 255));
    val[0] = $urandom;
    idx[1] = RegCapacity;
    val[1] = cap;
    idx[2] = RegSizeQuery;
    val[2] = {31'($urandom), sq};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx[i], val[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic make_text(int n_tokens);
    int         len;
    text_item_t last;
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) add_item(1'b1, space_byte(), 1'b0);
    for (int t = 0; t < n_tokens; t++) begin
      len = ($urandom_range(7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 5);
      for (int i = 0; i < len; i++) add_item(1'b1, token_byte(), 1'b0);
      if (t != n_tokens - 1 || $urandom_range(2) == 0)
        repeat ($urandom_range(1, 3)) add_item(1'b1, space_byte(), 1'b0);
      if ($urandom_range(19) == 0) add_item(1'b0, 8'($urandom), 1'b0);
    end
    case ($urandom_range(2))
      0: begin
        if (text_buf.size() != 0) begin
          last = text_buf.pop_back();
          last.end_of_text = 1'b1;
          text_buf.push_back(last);
        end else begin
          add_item(1'b0, 8'($urandom), 1'b1);
        end
      end
      1: add_item(1'b0, 8'($urandom), 1'b1);
      default: add_item(1'b1, space_byte(), 1'b1);
    endcase
  endtask

  task automatic make_noise(int n);
    repeat (n) add_item(1'($urandom_range(1)), 8'($urandom), $urandom_range(24) == 0);
    add_item(1'($urandom_range(1)), 8'($urandom), 1'b1);
  endtask

  initial begin
    logic [31:0] caps[8];
    int          phase_start;
    bit          paused;
    sb = new();
    caps[0] = 32'hFFFF_FFFF;
    caps[1] = 32'd3;
    caps[2] = 32'd0;
    caps[3] = 32'd65535;
    caps[4] = 32'd1;
    caps[5] = $urandom;
    caps[6] = 32'd2;
    caps[7] = 32'd5;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset register values, null byte, whitespace bounds, empty items
    add_item(1'b1, 8'h61, 1'b1);
    add_item(1'b0, 8'h00, 1'b0);
    add_item(1'b0, 8'hFF, 1'b1);
    add_item(1'b1, 8'h00, 1'b0);
    add_item(1'b1, 8'hFF, 1'b0);
    add_item(1'b1, 8'h20, 1'b0);
    add_item(1'b1, 8'h08, 1'b0);
    add_item(1'b1, 8'h0E, 1'b0);
    add_item(1'b1, 8'h09, 1'b0);
    add_item(1'b1, 8'h0A, 1'b0);
    add_item(1'b1, 8'h0B, 1'b0);
    add_item(1'b1, 8'h21, 1'b0);
    add_item(1'b1, 8'h0C, 1'b0);
    add_item(1'b1, 8'h0D, 1'b0);
    add_item(1'b1, 8'h7F, 1'b0);
    add_item(1'b1, 8'h80, 1'b1);
    add_item(1'b1, 8'h0D, 1'b1);
    send_buf();

    // zero capacity: nothing emitted, insufficient capacity
    configure(32'd0, 1'b0);
    add_item(1'b1, 8'h78, 1'b0);
    add_item(1'b1, 8'h20, 1'b0);
    add_item(1'b1, 8'h79, 1'b1);
    send_buf();

    // size query reports needed count
    configure(32'd1, 1'b1);
    add_item(1'b1, 8'h70, 1'b0);
    add_item(1'b1, 8'h09, 1'b0);
    add_item(1'b1, 8'h71, 1'b0);
    add_item(1'b1, 8'h20, 1'b0);
    add_item(1'b0, 8'h5A, 1'b1);
    send_buf();

    for (int p = 0; p < 8; p++) begin
      configure(caps[p], p == 2 || p == 5);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct <= 0; end
        1: begin send_idle_pct = 64; recv_stall_pct <= 0; end
        2: begin send_idle_pct = 0; recv_stall_pct <= 64; end
        default: begin send_idle_pct = 10; recv_stall_pct <= 10; end
      endcase
      // long receiver hold while the sender keeps going
      if (p % 4 == 0) hold_requests <= hold_requests + 1;
      phase_start = items_sent;
      paused = 1'b0;
      while (items_sent - phase_start < PhaseItems) begin
        if ($urandom_range(9) == 0) make_noise($urandom_range(1, 12));
        else make_text($urandom_range(0, 7));
        send_buf();
        if (!paused && (p == 1 || p == 5) && items_sent - phase_start > PhaseItems / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (2 * SettleCycles) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
